### rtl/core/ipipem_pkg.sv
// Shared constants and types for the IPI pending/enable multiplexer.
package ipipem_pkg;

	localparam int NUM_CPUS = 8;
	localparam int NUM_IPIS = 32;

	// Field widths
	localparam int OP_W   = 2;
	localparam int CPU_W  = 3;
	localparam int IDX_W  = 5;
	localparam int TGT_W  = 8;
	localparam int MASK_W = 32;
	localparam int CNT_W  = 6;

	// Target bits beyond this are ignored
	localparam int TGT_CPUS = (NUM_CPUS < TGT_W) ? NUM_CPUS : TGT_W;

	localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(32);

	typedef logic [MASK_W-1:0] mask_t;

	localparam logic [OP_W-1:0] OP_MASK    = 2'd0;
	localparam logic [OP_W-1:0] OP_UNMASK  = 2'd1;
	localparam logic [OP_W-1:0] OP_SEND    = 2'd2;
	localparam logic [OP_W-1:0] OP_PROCESS = 2'd3;

endpackage

### rtl/core/ipi_pending_enable_mux.sv
// IPI pending/enable multiplexer: per-CPU mask state, input register, result register.
//
//   channel | signals                                              | dir
//   --------+------------------------------------------------------+-----
//   in      | in_valid, in_stall, opcode, requester_cpu,           | in
//           | ipi_index, target_cpus                               |
//   out     | out_valid, out_stall, parent_send, parent_cpus,      | out
//           | handled_ipis                                         |
//   cfg     | cfg_valid, cfg_ready, ipis_in_use                    | in
//
// One request per cycle when in_stall is low; results are held in the result register.
// The per-CPU enable and pending masks sit in flip-flops and are read and
// updated in the cycle a request moves from the input register to the result register.
// Reset clears all masks and sets the count to 32.
// out_stall holds the result register; the input register keeps taking
// requests until both stages are full and the result is stalled.
module ipi_pending_enable_mux (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [ipipem_pkg::OP_W-1:0]    opcode,
	input  logic [ipipem_pkg::CPU_W-1:0]   requester_cpu,
	input  logic [ipipem_pkg::IDX_W-1:0]   ipi_index,
	input  logic [ipipem_pkg::TGT_W-1:0]   target_cpus,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           parent_send,
	output logic [ipipem_pkg::TGT_W-1:0]   parent_cpus,
	output logic [ipipem_pkg::MASK_W-1:0]  handled_ipis,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ipipem_pkg::CNT_W-1:0]   ipis_in_use
);
	import ipipem_pkg::*;

	logic             valid_s1;
	logic [OP_W-1:0]  op_s1;
	logic [CPU_W-1:0] req_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [TGT_W-1:0] tgt_s1;

	mask_t enable_q  [NUM_CPUS];
	mask_t pending_q [NUM_CPUS];
	logic [CNT_W-1:0] count_q;

	logic out_valid_q;
	logic psend_q;
	logic [TGT_W-1:0] pcpus_q;
	mask_t handled_q;

	logic advance;
	logic take_in;

	mask_t enable_d  [NUM_CPUS];
	mask_t pending_d [NUM_CPUS];
	logic psend_d;
	logic [TGT_W-1:0] pcpus_d;
	mask_t handled_d;

	logic req_ok;
	logic idx_ok;
	mask_t ibit;
	mask_t req_en;
	mask_t req_pend;
	mask_t lim_mask;

	assign advance   = valid_s1 && !(out_valid_q && out_stall);
	assign in_stall  = valid_s1 && out_valid_q && out_stall;
	assign take_in   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	assign out_valid    = out_valid_q;
	assign parent_send  = psend_q;
	assign parent_cpus  = pcpus_q;
	assign handled_ipis = handled_q;

	assign req_ok   = (32'(req_s1) < NUM_CPUS);
	assign idx_ok   = (32'(idx_s1) < NUM_IPIS);
	assign ibit     = idx_ok ? (mask_t'(1) << idx_s1) : '0;
	assign req_en   = req_ok ? enable_q[req_s1]  : '0;
	assign req_pend = req_ok ? pending_q[req_s1] : '0;

	// Bits below min(count, NUM_IPIS)
	always_comb begin
		for (int i = 0; i < MASK_W; i++) begin
			lim_mask[i] = (i < 32'(count_q)) && (i < NUM_IPIS);
		end
	end

	always_comb begin
		enable_d  = enable_q;
		pending_d = pending_q;
		psend_d   = 1'b0;
		pcpus_d   = '0;
		handled_d = '0;
		unique case (op_s1)
			OP_MASK: begin
				if (req_ok && idx_ok) begin
					enable_d[req_s1] = req_en & ~ibit;
				end
			end
			OP_UNMASK: begin
				if (req_ok && idx_ok) begin
					enable_d[req_s1] = req_en | ibit;
					if ((req_pend & ibit) != '0) begin
						psend_d = 1'b1;
						pcpus_d = TGT_W'(1) << req_s1;
					end
				end
			end
			OP_SEND: begin
				psend_d = 1'b1;
				for (int c = 0; c < TGT_CPUS; c++) begin
					if (tgt_s1[c]) begin
						pending_d[c] = pending_q[c] | ibit;
						if (((pending_q[c] & ibit) == '0) && ((enable_q[c] & ibit) != '0)) begin
							pcpus_d[c] = 1'b1;
						end
					end
				end
			end
			OP_PROCESS: begin
				if (req_ok) begin
					pending_d[req_s1] = req_pend & ~req_en;
					handled_d = req_pend & req_en & lim_mask;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			op_s1  <= opcode;
			req_s1 <= requester_cpu;
			idx_s1 <= ipi_index;
			tgt_s1 <= target_cpus;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CPUS; c++) begin
				enable_q[c]  <= '0;
				pending_q[c] <= '0;
			end
			count_q     <= CNT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				count_q <= ipis_in_use;
			end
			if (advance) begin
				enable_q    <= enable_d;
				pending_q   <= pending_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			psend_q   <= psend_d;
			pcpus_q   <= pcpus_d;
			handled_q <= handled_d;
		end
	end

endmodule

### rtl/core/ipipem_check.sv
// Port-level checks for the IPI pending/enable multiplexer, bound to the top level.
module ipipem_check (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic                           parent_send,
	input logic [ipipem_pkg::TGT_W-1:0]   parent_cpus,
	input logic [ipipem_pkg::MASK_W-1:0]  handled_ipis
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(parent_send)
			&& $stable(parent_cpus) && $stable(handled_ipis))
		else $error("stalled result changed");

	// No raised CPUs without a parent send
	a_cpus_need_send: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !parent_send |-> parent_cpus == '0)
		else $error("parent_cpus set without parent_send");

	// Process never signals a parent send
	a_handled_no_send: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && handled_ipis != '0 |-> !parent_send)
		else $error("handled_ipis together with parent_send");

	// A request taken while no result is shown or stalled reaches the output through the input and result registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !out_valid && !out_stall |=> ##1 out_valid)
		else $error("result missing after request");

endmodule

bind ipi_pending_enable_mux ipipem_check u_ipipem_check (.*);

### tb/sv/ipi_pending_enable_mux_tb.sv
// Self-checking testbench for the IPI pending/enable multiplexer.
module ipi_pending_enable_mux_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ipipem_pkg::*;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [CPU_W-1:0] cpu;
		logic [IDX_W-1:0] idx;
		logic [TGT_W-1:0] tgt;
	} ipi_req_t;

	typedef struct packed {
		logic             send;
		logic [TGT_W-1:0] cpus;
		mask_t            handled;
	} ipi_res_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [OP_W-1:0]   opcode = '0;
	logic [CPU_W-1:0]  requester_cpu = '0;
	logic [IDX_W-1:0]  ipi_index = '0;
	logic [TGT_W-1:0]  target_cpus = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              parent_send;
	logic [TGT_W-1:0]  parent_cpus;
	logic [MASK_W-1:0] handled_ipis;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [CNT_W-1:0]  ipis_in_use = '0;

	// predictor state
	mask_t            en_mask [NUM_CPUS] = '{default: '0};
	mask_t            pend_mask [NUM_CPUS] = '{default: '0};
	logic [CNT_W-1:0] ipi_limit = CNT_RESET;

	ipi_req_t req_fifo [$];
	ipi_res_t exp_results [$];

	bit in_took = 1'b0;
	bit no_idle = 1'b0;
	int issued = 0;
	int err_cnt = 0;
	int op_cnt [4] = '{default: 0};
	int raised_cnt = 0;
	int handled_cnt = 0;
	int cfg_writes = 0;
	int hot_base = 0;

	ipi_pending_enable_mux DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.requester_cpu(requester_cpu),
		.ipi_index(ipi_index),
		.target_cpus(target_cpus),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.parent_send(parent_send),
		.parent_cpus(parent_cpus),
		.handled_ipis(handled_ipis),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.ipis_in_use(ipis_in_use)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Apply one request to the mask state and return the expected result.
	function automatic ipi_res_t predict_ipi_result(ipi_req_t r);
		ipi_res_t res;
		mask_t    ibit;
		mask_t    was;
		mask_t    taken;
		bit       idx_ok;
		bit       cpu_ok;
		int       lim;
		res = '0;
		idx_ok = r.idx < NUM_IPIS;
		cpu_ok = r.cpu < NUM_CPUS;
		ibit = idx_ok ? (mask_t'(1) << r.idx) : '0;
		case (r.op)
			OP_MASK: begin
				if (cpu_ok && idx_ok)
					en_mask[r.cpu] &= ~ibit;
			end
			OP_UNMASK: begin
				if (cpu_ok && idx_ok) begin
					en_mask[r.cpu] |= ibit;
					if ((pend_mask[r.cpu] & ibit) != '0) begin
						res.send = 1'b1;
						res.cpus[r.cpu] = 1'b1;
					end
				end
			end
			OP_SEND: begin
				if (idx_ok) begin
					for (int c = 0; c < TGT_CPUS; c++) begin
						if (r.tgt[c]) begin
							was = pend_mask[c];
							pend_mask[c] = was | ibit;
							if ((was & ibit) == '0 && (en_mask[c] & ibit) != '0)
								res.cpus[c] = 1'b1;
						end
					end
				end
				res.send = 1'b1;
			end
			default: begin
				if (cpu_ok) begin
					lim = (ipi_limit > NUM_IPIS) ? NUM_IPIS : int'(ipi_limit);
					taken = pend_mask[r.cpu] & en_mask[r.cpu];
					pend_mask[r.cpu] &= ~en_mask[r.cpu];
					res.handled = taken & mask_t'((64'd1 << lim) - 64'd1);
				end
			end
		endcase
		return res;
	endfunction

	// request driver
	always @(negedge clk) begin
		ipi_req_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !in_took) begin
			// stalled: hold the request
		end else if (req_fifo.size() == 0
				|| (issued % 400 == 399 && exp_results.size() != 0)
				|| (!no_idle && $urandom_range(99) < 38)) begin
			in_valid <= 1'b0;
		end else begin
			nxt = req_fifo.pop_front();
			issued++;
			in_valid <= 1'b1;
			opcode <= nxt.op;
			requester_cpu <= nxt.cpu;
			ipi_index <= nxt.idx;
			target_cpus <= nxt.tgt;
		end
	end

	// result-side backpressure
	always @(negedge clk) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else
			out_stall <= !no_idle && ($urandom_range(99) < 38);
	end

	// monitor: record accepted requests, config writes, check results
	always @(posedge clk) begin
		ipi_req_t acc;
		ipi_res_t want;
		ipi_res_t want_chk;
		if (!arst_n) begin
			in_took = 1'b0;
		end else begin
			in_took = in_valid && !in_stall;
			if (in_took) begin
				acc = {opcode, requester_cpu, ipi_index, target_cpus};
				want = predict_ipi_result(acc);
				op_cnt[acc.op]++;
				if (want.cpus != '0)
					raised_cnt++;
				if (want.handled != '0)
					handled_cnt++;
				exp_results.push_back(want);
			end
			if (cfg_valid && cfg_ready) begin
				ipi_limit = ipis_in_use;
				cfg_writes++;
			end
			if (out_valid && !out_stall) begin
				if (exp_results.size() == 0) begin
					$error("unexpected result: parent_send %0b parent_cpus %02h handled_ipis %08h",
						parent_send, parent_cpus, handled_ipis);
					err_cnt++;
				end else begin
					want_chk = exp_results.pop_front();
					if (parent_send !== want_chk.send) begin
						$error("parent_send: expected %0b, got %0b", want_chk.send, parent_send);
						err_cnt++;
					end
					if (parent_cpus !== want_chk.cpus) begin
						$error("parent_cpus: expected %02h, got %02h", want_chk.cpus, parent_cpus);
						err_cnt++;
					end
					if (handled_ipis !== want_chk.handled) begin
						$error("handled_ipis: expected %08h, got %08h",
							want_chk.handled, handled_ipis);
						err_cnt++;
					end
				end
			end
		end
	end

	task automatic add_req(input int op, input int cpu, input int idx, input int tgt);
		ipi_req_t r;
		r.op = OP_W'(op);
		r.cpu = CPU_W'(cpu);
		r.idx = IDX_W'(idx);
		r.tgt = TGT_W'(tgt);
		req_fifo.push_back(r);
	endtask

	function automatic int pick_idx();
		if ($urandom_range(99) < 70)
			return hot_base + $urandom_range(3);
		return $urandom_range(NUM_IPIS - 1);
	endfunction

	function automatic int pick_tgt();
		case ($urandom_range(9))
			0: return 0;
			1: return 8'hFF;
			2, 3, 4: return 1 << $urandom_range(TGT_W - 1);
			default: return $urandom_range(255);
		endcase
	endfunction

	// Mostly mask-or-unmask/send/process sequences on one CPU and index, the rest loose noise.
	task automatic push_random(input int n);
		int left;
		int cpu;
		int idx;
		left = n;
		while (left > 0) begin
			if ($urandom_range(99) < 55 && left >= 3) begin
				cpu = $urandom_range(NUM_CPUS - 1);
				idx = pick_idx();
				if ($urandom_range(3) == 0)
					add_req(OP_MASK, cpu, idx, pick_tgt());
				else
					add_req(OP_UNMASK, cpu, idx, pick_tgt());
				add_req(OP_SEND, $urandom_range(7), idx, pick_tgt() | (1 << cpu));
				add_req(OP_PROCESS, cpu, pick_idx(), pick_tgt());
				left -= 3;
			end else begin
				add_req($urandom_range(3), $urandom_range(7), pick_idx(), pick_tgt());
				left--;
			end
		end
	endtask

	task automatic wait_drained();
		while (req_fifo.size() != 0 || exp_results.size() != 0 || in_valid)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_limit(input int cnt);
		wait_drained();
		@(negedge clk);
		cfg_valid <= 1'b1;
		ipis_in_use <= CNT_W'(cnt);
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_phase(input int cnt, input bit quiet);
		write_limit(cnt);
		no_idle = quiet;
		hot_base = $urandom_range(NUM_IPIS - 4);
		push_random(270);
		wait_drained();
		no_idle = 1'b0;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset count of 32: basic pending/enable interplay at the index and CPU extremes
		add_req(OP_SEND, 0, 0, 8'hFF);
		add_req(OP_UNMASK, 0, 0, 0);
		add_req(OP_UNMASK, 7, 31, 0);
		add_req(OP_SEND, 3, 31, 8'h80);
		add_req(OP_SEND, 3, 31, 8'hFF);
		add_req(OP_PROCESS, 7, 0, 0);
		add_req(OP_PROCESS, 0, 0, 0);
		add_req(OP_MASK, 0, 0, 0);
		add_req(OP_SEND, 5, 0, 8'h01);
		add_req(OP_PROCESS, 0, 0, 0);
		add_req(OP_UNMASK, 0, 0, 0);
		add_req(OP_PROCESS, 0, 0, 0);
		add_req(OP_SEND, 2, 17, 8'h00);
		add_req(OP_MASK, 7, 31, 0);
		add_req(OP_PROCESS, 7, 0, 0);
		add_req(OP_PROCESS, 4, 31, 8'hFF);

		// count of one: bits above it are cleared but not reported
		write_limit(1);
		add_req(OP_UNMASK, 3, 5, 0);
		add_req(OP_SEND, 6, 5, 8'h08);
		add_req(OP_PROCESS, 3, 0, 0);
		add_req(OP_SEND, 6, 5, 8'h08);
		add_req(OP_UNMASK, 3, 0, 0);
		add_req(OP_SEND, 1, 0, 8'h08);
		add_req(OP_PROCESS, 3, 0, 0);

		random_phase(0, 1'b0);
		random_phase(63, 1'b0);
		random_phase(32, 1'b1);
		random_phase(1, 1'b0);
		random_phase($urandom_range(31, 2), 1'b0);
		random_phase($urandom_range(62, 33), 1'b0);
		random_phase(32, 1'b0);

		wait_drained();
		repeat (6) @(posedge clk);
		$display("Ran %0d requests (mask %0d, unmask %0d, send %0d, process %0d), %0d count writes",
			issued, op_cnt[OP_MASK], op_cnt[OP_UNMASK], op_cnt[OP_SEND], op_cnt[OP_PROCESS],
			cfg_writes);
		$display("Results raising a parent: %0d, process results with handled bits: %0d",
			raised_cnt, handled_cnt);
		if (err_cnt == 0 && exp_results.size() == 0)
			$display("ipi_pending_enable_mux verification clean");
		else
			$display("ipi_pending_enable_mux verification failed");
		$finish;
	end

	initial begin
		#3600000;
		$display("ipi_pending_enable_mux verification failed");
		$finish;
	end

endmodule
